/* design/loet_pkg.sv */
// ----------------------------------------------------------------------------
// loet_pkg
// Shared sizes, types and codes of the lock-order edge tracker.
// ----------------------------------------------------------------------------
package loet_pkg;

  localparam int unsigned SLOTS_PER_THREAD = 16;
  localparam int unsigned THREAD_ROWS      = 64;

  localparam int unsigned RowW      = (THREAD_ROWS > 1) ? $clog2(THREAD_ROWS) : 1;
  localparam int unsigned SlotW     = $clog2(SLOTS_PER_THREAD);
  localparam int unsigned ThreadInW = 6;
  localparam int unsigned LockW     = 64;
  localparam int unsigned StackW    = 32;

  typedef logic [RowW-1:0]  row_idx_t;
  typedef logic [SlotW-1:0] slot_idx_t;

  typedef struct packed {
    logic [StackW-1:0] stack;
    logic [LockW-1:0]  lock;
  } slot_t;

  typedef slot_t [SLOTS_PER_THREAD-1:0] row_t;

  typedef struct packed {
    logic     en;
    row_idx_t addr;
  } row_rd_t;

  typedef struct packed {
    logic     en;
    row_idx_t addr;
    row_t     data;
  } row_wr_t;

  typedef enum logic {
    CMD_ACQUIRE = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_e;

  typedef enum logic {
    KIND_EDGE   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    STAT_ADDED    = 2'd0,
    STAT_HELD     = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_RELEASED = 2'd3
  } status_e;

  typedef row_idx_t [2**ThreadInW-1:0] row_map_t;

  // thread_row reduced modulo THREAD_ROWS, built at elaboration
  function automatic row_map_t build_row_map();
    row_map_t m;
    for (int i = 0; i < 2**ThreadInW; i++) begin
      m[i] = row_idx_t'(i % THREAD_ROWS);
    end
    return m;
  endfunction

endpackage

/* design/loet_row_store.sv */
// ----------------------------------------------------------------------------
// loet_row_store
// Row-wide held-lock memory, one row per thread, registered read.
// Per-row valid bits make an unwritten row read as all free.
// ----------------------------------------------------------------------------
module loet_row_store (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  loet_pkg::row_rd_t rd_i,
  input  loet_pkg::row_wr_t wr_i,
  output loet_pkg::row_t    rd_data_o
);

  loet_pkg::row_t                     mem_q [loet_pkg::THREAD_ROWS];
  logic [loet_pkg::THREAD_ROWS-1:0]   valid_q;
  loet_pkg::row_t                     rd_data_q;
  logic                               rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      rd_data_q <= mem_q[rd_i.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      if (rd_i.en) begin
        rd_valid_q <= valid_q[rd_i.addr];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

/* design/lock_order_edge_tracker_unit.sv */
// ----------------------------------------------------------------------------
// lock_order_edge_tracker_unit
// Per-thread held-lock table: an acquire of a lock not yet held emits one edge
// per held lock; every request ends in a status; release clears matching slots.
// ----------------------------------------------------------------------------
// channel  dir  tdata                                         tuser        tlast
// s_axis   in   thread_row, lock_address, call_stack_id       command      -
// m_axis   out  earlier_lock/stack, later_lock/stack,         result_kind  last
//               edge_thread, status
//
// A release or an acquire of a lock already held goes from decide straight
// to status; any other acquire walks the row read from the row memory one
// slot per cycle while the output is not stalled, then gives its status.
// Reset clears per-row valid bits at once; no clearing pass is needed.
// A stalled output holds the walk; a new request is taken while the last
// status still waits.
// ----------------------------------------------------------------------------
module lock_order_edge_tracker_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [5:0] thread_row, [69:6] lock_address, [101:70] call_stack_id, [103:102] 0
  input  logic [103:0] s_axis_tdata,
  // [0] command
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [63:0] earlier_lock, [95:64] earlier_stack, [159:96] later_lock,
  // [191:160] later_stack, [197:192] edge_thread, [199:198] status
  output logic [199:0] m_axis_tdata,
  // [0] result_kind
  output logic [0:0]   m_axis_tuser,
  output logic         m_axis_tlast
);

  localparam loet_pkg::row_map_t  RowMap   = loet_pkg::build_row_map();
  localparam loet_pkg::slot_idx_t LastSlot =
    loet_pkg::slot_idx_t'(loet_pkg::SLOTS_PER_THREAD - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_WALK,
    S_STATUS
  } state_e;

  typedef struct packed {
    loet_pkg::status_e              status;
    logic [loet_pkg::ThreadInW-1:0] thread;
    logic [loet_pkg::StackW-1:0]    later_stack;
    logic [loet_pkg::LockW-1:0]     later_lock;
    logic [loet_pkg::StackW-1:0]    earlier_stack;
    logic [loet_pkg::LockW-1:0]     earlier_lock;
  } out_data_t;

  state_e                          state_q;
  loet_pkg::cmd_e                  cmd_q;
  loet_pkg::row_idx_t              row_q;
  logic [loet_pkg::LockW-1:0]      addr_q;
  logic [loet_pkg::StackW-1:0]     sid_q;
  loet_pkg::slot_idx_t             slot_q;
  loet_pkg::status_e               status_q;

  logic                            out_valid_q;
  loet_pkg::kind_e                 out_kind_q;
  logic                            out_last_q;
  out_data_t                       out_q;

  loet_pkg::row_rd_t               rd;
  loet_pkg::row_wr_t               wr;
  loet_pkg::row_t                  cur_row;
  loet_pkg::row_t                  acq_row;
  loet_pkg::row_t                  rel_row;
  logic [loet_pkg::SLOTS_PER_THREAD-1:0] hit;
  logic [loet_pkg::SLOTS_PER_THREAD-1:0] empty;
  loet_pkg::slot_t                 walk_slot;
  logic                            accept;
  logic                            load_ok;
  logic                            out_set;
  logic [loet_pkg::ThreadInW-1:0]  in_thread;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign load_ok       = !out_valid_q || m_axis_tready;
  assign in_thread     = s_axis_tdata[5:0];

  assign rd.en   = accept;
  assign rd.addr = RowMap[in_thread];

  loet_row_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_i      (rd),
    .wr_i      (wr),
    .rd_data_o (cur_row)
  );

  always_comb begin
    logic taken;
    taken   = 1'b0;
    acq_row = cur_row;
    rel_row = cur_row;
    for (int i = 0; i < loet_pkg::SLOTS_PER_THREAD; i++) begin
      hit[i]   = (cur_row[i].lock == addr_q);
      empty[i] = (cur_row[i].lock == '0);
      if (empty[i] && !taken) begin
        acq_row[i].lock  = addr_q;
        acq_row[i].stack = sid_q;
        taken            = 1'b1;
      end
      if (hit[i]) begin
        rel_row[i] = '0;
      end
    end
  end

  assign wr.en   = (state_q == S_DECIDE) &&
                   ((cmd_q == loet_pkg::CMD_RELEASE) || (!(|hit) && (|empty)));
  assign wr.addr = row_q;
  assign wr.data = (cmd_q == loet_pkg::CMD_RELEASE) ? rel_row : acq_row;

  assign walk_slot = cur_row[slot_q];

  assign out_set = load_ok && (((state_q == S_WALK) && (walk_slot.lock != '0)) ||
                               (state_q == S_STATUS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      slot_q      <= '0;
    end else begin
      if (out_set) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            cmd_q   <= loet_pkg::cmd_e'(s_axis_tuser[0]);
            row_q   <= RowMap[in_thread];
            addr_q  <= s_axis_tdata[69:6];
            sid_q   <= s_axis_tdata[101:70];
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          slot_q <= '0;
          if (cmd_q == loet_pkg::CMD_RELEASE) begin
            status_q <= loet_pkg::STAT_RELEASED;
            state_q  <= S_STATUS;
          end else if (|hit) begin
            status_q <= loet_pkg::STAT_HELD;
            state_q  <= S_STATUS;
          end else begin
            status_q <= (|empty) ? loet_pkg::STAT_ADDED : loet_pkg::STAT_FULL;
            state_q  <= S_WALK;
          end
        end
        S_WALK: begin
          if (load_ok) begin
            if (walk_slot.lock != '0) begin
              out_kind_q          <= loet_pkg::KIND_EDGE;
              out_last_q          <= 1'b0;
              out_q.status        <= loet_pkg::STAT_ADDED;
              out_q.thread        <= loet_pkg::ThreadInW'(row_q);
              out_q.later_stack   <= sid_q;
              out_q.later_lock    <= addr_q;
              out_q.earlier_stack <= walk_slot.stack;
              out_q.earlier_lock  <= walk_slot.lock;
            end
            slot_q <= slot_q + 1'b1;
            if (slot_q == LastSlot) begin
              state_q <= S_STATUS;
            end
          end
        end
        S_STATUS: begin
          if (load_ok) begin
            out_kind_q          <= loet_pkg::KIND_STATUS;
            out_last_q          <= 1'b1;
            out_q.status        <= status_q;
            out_q.thread        <= loet_pkg::ThreadInW'(row_q);
            out_q.later_stack   <= sid_q;
            out_q.later_lock    <= addr_q;
            out_q.earlier_stack <= '0;
            out_q.earlier_lock  <= '0;
            state_q             <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

endmodule
